>>> src/mbps_pkg.sv
// package for the masked byte pattern scan unit
// holds the shared constants, register indexes and the structs passed between modules
// no dependencies
package mbps_pkg;

  localparam int MAX_PATTERN_BYTES_DEFAULT = 16;
  localparam int REG_PATTERN_BYTES = 16;
  localparam int ADDR_W = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_WILDCARD_MASK  = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_BASE_ADDRESS   = 3'd4,
    REG_REGION_SIZE    = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [8*REG_PATTERN_BYTES-1:0] pattern;
    logic [REG_PATTERN_BYTES-1:0]   wildcard_mask;
    logic [4:0]                     pattern_length;
    logic [ADDR_W-1:0]              region_size;
  } scan_cfg_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] offset;
  } scan_result_t;

  typedef struct packed {
    logic                   full;
    logic                   empty;
    logic [QUEUE_CNT_W-1:0] count;
  } queue_status_t;

endpackage

>>> src/masked_byte_pattern_scan_unit.sv
// top level of the masked byte pattern scan unit: configuration registers,
// front end, result queue and output stage
// depends on mbps_pkg, mbps_front, mbps_queue, mbps_back
//
// The unit takes one region byte per clock cycle. Every byte is compared
// combinationally against the masked pattern over the whole window, so a byte
// that ends a search puts its result into a four-entry queue at the cycle it
// is accepted; the result then passes from the queue into the output register
// before it shows at the output. in_ready drops only while that queue is full,
// which needs the output side to be stalled for several region results in a row.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data and take effect on the next byte; writes to indexes beyond the
// register list are ignored.
module masked_byte_pattern_scan_unit import mbps_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             data_byte,
  input  logic                   region_start,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   found,
  output logic [ADDR_W-1:0]      match_address,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [63:0]       pattern_low;
  logic [63:0]       pattern_high;
  logic [15:0]       wildcard_mask;
  logic [4:0]        pattern_length;
  logic [ADDR_W-1:0] base_address;
  logic [ADDR_W-1:0] region_size;

  scan_cfg_t     cfg;
  queue_status_t q_status;
  scan_result_t  push_data;
  scan_result_t  head;
  logic          push;
  logic          pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      wildcard_mask  <= '0;
      pattern_length <= 5'd1;
      base_address   <= '0;
      region_size    <= '0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_WILDCARD_MASK:  wildcard_mask  <= cfg_data[15:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[4:0];
        REG_BASE_ADDRESS:   base_address   <= cfg_data[ADDR_W-1:0];
        REG_REGION_SIZE:    region_size    <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.pattern        = {pattern_high, pattern_low};
  assign cfg.wildcard_mask  = wildcard_mask;
  assign cfg.pattern_length = pattern_length;
  assign cfg.region_size    = region_size;

  mbps_front #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .region_start (region_start),
    .cfg          (cfg),
    .q_status     (q_status),
    .push         (push),
    .push_data    (push_data)
  );

  mbps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  mbps_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_status      (q_status),
    .pop           (pop),
    .base_address  (base_address),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .match_address (match_address)
  );

  // queue never takes a transaction it has no room for
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full || pop)
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("result queue count out of range");

  // a not-found result carries address zero
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_address == '0)
    else $error("not-found result with nonzero address");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped result not presented");

endmodule

>>> src/mbps_front.sv
// front end of the scan unit: accepts bytes, shifts the window and compares it
// with the masked pattern, pushing one result per region into the queue
// depends on mbps_pkg
module mbps_front import mbps_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          region_start,
  input  scan_cfg_t     cfg,
  input  queue_status_t q_status,
  output logic          push,
  output scan_result_t  push_data
);

  localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

  logic [7:0]        window [MAX_PATTERN_BYTES];
  logic [7:0]        win_next [MAX_PATTERN_BYTES];
  logic [7:0]        pat [MAX_PATTERN_BYTES];
  logic              wild [MAX_PATTERN_BYTES];
  logic [ADDR_W-1:0] bytes_seen;
  logic [ADDR_W-1:0] seen_base;
  logic [ADDR_W-1:0] seen_next;
  logic              search_done;
  logic [LEN_W-1:0]  eff_len;
  logic              accept;
  logic              active;
  logic              empty_region;
  logic              matched;
  logic              hit;
  logic              region_end;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // pattern bytes above the register width read as zero and never wild
  for (genvar g = 0; g < MAX_PATTERN_BYTES; g++) begin : g_pat
    if (g < REG_PATTERN_BYTES) begin : g_reg
      assign pat[g]  = cfg.pattern[8*g +: 8];
      assign wild[g] = cfg.wildcard_mask[g];
    end else begin : g_zero
      assign pat[g]  = 8'd0;
      assign wild[g] = 1'b0;
    end
  end

  for (genvar g = 0; g < MAX_PATTERN_BYTES; g++) begin : g_win
    if (g == 0) begin : g_head
      assign win_next[g] = data_byte;
    end else begin : g_tail
      assign win_next[g] = region_start ? 8'd0 : window[g-1];
    end
  end

  always_comb begin
    if (cfg.pattern_length == 5'd0) begin
      eff_len = LEN_W'(1);
    end else if (32'(cfg.pattern_length) > 32'(MAX_PATTERN_BYTES)) begin
      eff_len = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      eff_len = LEN_W'(cfg.pattern_length);
    end
  end

  assign seen_base = region_start ? '0 : bytes_seen;
  assign seen_next = (seen_base == '1) ? seen_base : seen_base + 1'b1;

  // pattern byte k lines up with entry eff_len-1-k of the next window (win_next)
  always_comb begin
    logic [LEN_W-1:0] pos;
    matched = 1'b1;
    pos     = '0;
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      pos = eff_len - LEN_W'(k) - LEN_W'(1);
      if ((LEN_W'(k) < eff_len) && !wild[k] && (win_next[pos[IDX_W-1:0]] != pat[k])) begin
        matched = 1'b0;
      end
    end
  end

  assign active       = region_start || !search_done;
  assign empty_region = region_start && (cfg.region_size == '0);
  assign hit          = (seen_next >= ADDR_W'(eff_len)) && matched;
  assign region_end   = seen_next >= cfg.region_size;

  assign push             = accept && (empty_region || (active && (hit || region_end)));
  assign push_data.found  = !empty_region && hit;
  assign push_data.offset = (!empty_region && hit) ? seen_next - ADDR_W'(eff_len) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_done <= 1'b1;
      bytes_seen  <= '0;
    end else if (accept) begin
      if (empty_region) begin
        search_done <= 1'b1;
        bytes_seen  <= '0;
      end else if (active) begin
        search_done <= hit || region_end;
        bytes_seen  <= seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active && !empty_region) begin
      for (int p = 0; p < MAX_PATTERN_BYTES; p++) begin
        window[p] <= win_next[p];
      end
    end
  end

endmodule

>>> src/mbps_queue.sv
// short result queue between the front end and the output stage
// depends on mbps_pkg
module mbps_queue import mbps_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  scan_result_t  push_data,
  input  logic          pop,
  output scan_result_t  head,
  output queue_status_t status
);

  scan_result_t           mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign head         = mem[rd_ptr];
  assign status.count = count;
  assign status.full  = count == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/mbps_back.sv
// output stage: takes results from the queue, adds the base address to the offset
// of a found match and holds them in the output register until taken
// depends on mbps_pkg
module mbps_back import mbps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  scan_result_t      head,
  input  queue_status_t     q_status,
  output logic              pop,
  input  logic [ADDR_W-1:0] base_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              found,
  output logic [ADDR_W-1:0] match_address
);

  assign pop = !q_status.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      found         <= head.found;
      match_address <= head.found ? base_address + head.offset : '0;
    end
  end

endmodule
